[rtl/bbe_pkg.sv]
// Shared types, constants, microprogram and arithmetic helpers for the ball stepper.
package bbe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int STEP_FRAC = 12;
    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int ARENA_W   = 31;
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    localparam int PROD_W    = DATA_W + DT_W + 1;
    localparam int INC_W     = PROD_W - STEP_FRAC;
    localparam int BOUND_W   = DATA_W + 3;
    localparam int WIDE_W    = 40;
    localparam int PC_W      = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [DATA_W-1:0]  MASS_RST   = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [DATA_W-1:0]  RADIUS_RST = DATA_W'(64'd10 << FRAC_BITS);
    localparam logic [ARENA_W-1:0] LENGTH_RST = ARENA_W'(64'd640 << FRAC_BITS);
    localparam logic [ARENA_W-1:0] HEIGHT_RST = ARENA_W'(64'd480 << FRAC_BITS);

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_X   = 3'd0,
        CFG_ACCEL_Y   = 3'd1,
        CFG_MASS      = 3'd2,
        CFG_RADIUS    = 3'd3,
        CFG_ARENA_LEN = 3'd4,
        CFG_ARENA_HGT = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STORE,
        OP_CLEAN,
        OP_MUL_V,
        OP_ADD_P,
        OP_MUL_Q,
        OP_ADD_V,
        OP_BOUND,
        OP_REFL_LO,
        OP_REFL_HI,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        JC_NONE,
        JC_ALWAYS,
        JC_LOAD,
        JC_CLEAN,
        JC_DIV_BUSY,
        JC_OUT_FULL
    } jc_t;

    localparam logic AX_X = 1'b0;
    localparam logic AX_Y = 1'b1;

    typedef struct packed {
        op_t             op;
        logic            axis;
        jc_t             jc;
        logic [PC_W-1:0] target;
        logic            last;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic axis;
    } ctrl_t;

    typedef struct packed {
        logic is_load;
        logic dirty;
        logic div_busy;
        logic out_full;
    } stat_t;

    localparam logic [PC_W-1:0] PC_WAIT_X = 5'd3;
    localparam logic [PC_W-1:0] PC_WAIT_Y = 5'd6;
    localparam logic [PC_W-1:0] PC_EULER  = 5'd9;
    localparam logic [PC_W-1:0] PC_OUT    = 5'd23;
    localparam logic [PC_W-1:0] PC_LOAD   = 5'd24;

    function automatic uword_t uw(op_t op, logic axis, jc_t jc, logic [PC_W-1:0] target,
                                  logic last);
        uword_t w;
        w.op     = op;
        w.axis   = axis;
        w.jc     = jc;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    // microprogram: quotient refresh (only after a force or mass write), Euler, walls
    function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = uw(OP_NOP,       AX_X, JC_LOAD,     PC_LOAD,   1'b0);
            5'd1:    w = uw(OP_NOP,       AX_X, JC_CLEAN,    PC_EULER,  1'b0);
            5'd2:    w = uw(OP_DIV_START, AX_X, JC_NONE,     '0,        1'b0);
            5'd3:    w = uw(OP_NOP,       AX_X, JC_DIV_BUSY, PC_WAIT_X, 1'b0);
            5'd4:    w = uw(OP_DIV_STORE, AX_X, JC_NONE,     '0,        1'b0);
            5'd5:    w = uw(OP_DIV_START, AX_Y, JC_NONE,     '0,        1'b0);
            5'd6:    w = uw(OP_NOP,       AX_Y, JC_DIV_BUSY, PC_WAIT_Y, 1'b0);
            5'd7:    w = uw(OP_DIV_STORE, AX_Y, JC_NONE,     '0,        1'b0);
            5'd8:    w = uw(OP_CLEAN,     AX_X, JC_NONE,     '0,        1'b0);
            5'd9:    w = uw(OP_MUL_V,     AX_X, JC_NONE,     '0,        1'b0);
            5'd10:   w = uw(OP_ADD_P,     AX_X, JC_NONE,     '0,        1'b0);
            5'd11:   w = uw(OP_MUL_Q,     AX_X, JC_NONE,     '0,        1'b0);
            5'd12:   w = uw(OP_ADD_V,     AX_X, JC_NONE,     '0,        1'b0);
            5'd13:   w = uw(OP_MUL_V,     AX_Y, JC_NONE,     '0,        1'b0);
            5'd14:   w = uw(OP_ADD_P,     AX_Y, JC_NONE,     '0,        1'b0);
            5'd15:   w = uw(OP_MUL_Q,     AX_Y, JC_NONE,     '0,        1'b0);
            5'd16:   w = uw(OP_ADD_V,     AX_Y, JC_NONE,     '0,        1'b0);
            5'd17:   w = uw(OP_BOUND,     AX_X, JC_NONE,     '0,        1'b0);
            5'd18:   w = uw(OP_REFL_LO,   AX_X, JC_NONE,     '0,        1'b0);
            5'd19:   w = uw(OP_REFL_HI,   AX_X, JC_NONE,     '0,        1'b0);
            5'd20:   w = uw(OP_BOUND,     AX_Y, JC_NONE,     '0,        1'b0);
            5'd21:   w = uw(OP_REFL_LO,   AX_Y, JC_NONE,     '0,        1'b0);
            5'd22:   w = uw(OP_REFL_HI,   AX_Y, JC_NONE,     '0,        1'b0);
            5'd23:   w = uw(OP_OUT,       AX_X, JC_OUT_FULL, PC_OUT,    1'b1);
            5'd24:   w = uw(OP_LOAD,      AX_X, JC_ALWAYS,   PC_OUT,    1'b0);
            default: w = uw(OP_NOP,       AX_X, JC_NONE,     '0,        1'b1);
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(logic signed [WIDE_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > WIDE_W'(S32_MAX))
            r = S32_MAX;
        else if (x < WIDE_W'(S32_MIN))
            r = S32_MIN;
        else
            r = x[DATA_W-1:0];
        return r;
    endfunction

    // floor(-v / 2)
    function automatic logic signed [DATA_W-1:0] neg_half(logic signed [DATA_W-1:0] v);
        logic signed [DATA_W:0] n;
        n = -(DATA_W+1)'(v);
        return n[DATA_W:1];
    endfunction

endpackage

[rtl/bbe_if.sv]
// Request and response channel interfaces of the ball stepper.
interface bbe_req_if import bbe_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [DT_W-1:0]          time_step;
    logic signed [DATA_W-1:0] load_x;
    logic signed [DATA_W-1:0] load_y;
    logic signed [DATA_W-1:0] load_vx;
    logic signed [DATA_W-1:0] load_vy;

    modport source (output valid, req_type, time_step, load_x, load_y, load_vx, load_vy,
                    input ready);
    modport sink   (input valid, req_type, time_step, load_x, load_y, load_vx, load_vy,
                    output ready);
endinterface

interface bbe_rsp_if import bbe_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_vx;
    logic signed [DATA_W-1:0] out_vy;

    modport source (output valid, out_x, out_y, out_vx, out_vy, input ready);
    modport sink   (input valid, out_x, out_y, out_vx, out_vy, output ready);
endinterface

[rtl/bouncing_ball_euler_step.sv]
// Top level of the fixed-point ball stepper with wall reflection.
//
//  channel  dir  handshake        words
//  req      in   valid / ready    req_type, time_step, load_x/y/vx/vy
//  rsp      out  valid / ready    out_x, out_y, out_vx, out_vy
//  cfg      in   cfg_we only      cfg_index, cfg_data
//
// A load goes from acceptance to its result through the load and output steps, a tick through
// the Euler and wall steps, as set by the microprogram. After a force or mass write the next
// tick first runs the divider for both axes. One word at a time; req is taken again once the
// result sits in the output register.
// A stalled rsp holds the sequencer on its output step. Reset is immediate, no sweep.
module bouncing_ball_euler_step import bbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    bbe_req_if.sink              req,
    bbe_rsp_if.source            rsp
);

    ctrl_t ctrl;
    stat_t stat;
    logic  ready;
    logic  accept;

    assign req.ready = ready;
    assign accept    = req.valid && ready;

    bbe_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .stat   (stat),
        .ctrl   (ctrl),
        .ready  (ready)
    );

    bbe_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .accept    (accept),
        .req_type  (req.req_type),
        .time_step (req.time_step),
        .load_x    (req.load_x),
        .load_y    (req.load_y),
        .load_vx   (req.load_vx),
        .load_vy   (req.load_vy),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .out_x     (rsp.out_x),
        .out_y     (rsp.out_y),
        .out_vx    (rsp.out_vx),
        .out_vy    (rsp.out_vy),
        .stat      (stat)
    );

endmodule

[rtl/bbe_div.sv]
// Restoring divider, one quotient bit per cycle.
module bbe_div import bbe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        diff      = trial - {1'b0, divisor};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[rtl/bbe_dp.sv]
// Datapath: configuration, ball state, cached force/mass, multiplier, wall logic, result word.
module bbe_dp import bbe_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ctrl_t                    ctrl,
    input  logic                     accept,
    input  logic                     req_type,
    input  logic [DT_W-1:0]          time_step,
    input  logic signed [DATA_W-1:0] load_x,
    input  logic signed [DATA_W-1:0] load_y,
    input  logic signed [DATA_W-1:0] load_vx,
    input  logic signed [DATA_W-1:0] load_vy,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y,
    output logic signed [DATA_W-1:0] out_vx,
    output logic signed [DATA_W-1:0] out_vy,
    output stat_t                    stat
);

    logic signed [DATA_W-1:0]  accel_x_reg, accel_y_reg;
    logic [DATA_W-1:0]         mass_reg, radius_reg;
    logic [ARENA_W-1:0]        arena_len_reg, arena_hgt_reg;
    logic                      dirty_reg;

    logic signed [DATA_W-1:0]  px_reg, py_reg, vx_reg, vy_reg;
    logic signed [DATA_W-1:0]  qx_reg, qy_reg;

    logic                      item_load_reg;
    logic [DT_W-1:0]           item_dt_reg;
    logic signed [DATA_W-1:0]  item_x_reg, item_y_reg, item_vx_reg, item_vy_reg;

    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [BOUND_W-1:0] bound_reg, bound_next;

    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_x_reg, out_y_reg, out_vx_reg, out_vy_reg;

    logic signed [DATA_W-1:0]  sel_p, sel_v, sel_q, sel_a, mul_src, base;
    logic [ARENA_W-1:0]        sel_arena;
    logic [DATA_W-1:0]         a_mag;
    logic [DIV_W-1:0]          dividend;
    logic                      div_busy;
    logic [DIV_W-1:0]          div_quo;
    logic                      quo_big;
    logic signed [DATA_W-1:0]  q_val;
    logic signed [INC_W-1:0]   inc;
    logic signed [WIDE_W-1:0]  sum;
    logic signed [WIDE_W-1:0]  mirror;
    logic                      lo_hit, hi_hit;
    logic                      p_we, v_we;
    logic signed [DATA_W-1:0]  p_new, v_new;
    logic                      out_full;

    bbe_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.op == OP_DIV_START),
        .dividend (dividend),
        .divisor  (mass_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        sel_p     = ctrl.axis ? py_reg : px_reg;
        sel_v     = ctrl.axis ? vy_reg : vx_reg;
        sel_q     = ctrl.axis ? qy_reg : qx_reg;
        sel_a     = ctrl.axis ? accel_y_reg : accel_x_reg;
        sel_arena = ctrl.axis ? arena_hgt_reg : arena_len_reg;

        a_mag    = sel_a[DATA_W-1] ? DATA_W'(-sel_a) : DATA_W'(sel_a);
        dividend = DIV_W'(a_mag) << FRAC_BITS;
        quo_big  = |div_quo[DIV_W-1:DATA_W-1];
        if (a_mag == '0)
            q_val = '0;
        else if (sel_a[DATA_W-1])
            q_val = quo_big ? S32_MIN : -$signed(div_quo[DATA_W-1:0]);
        else
            q_val = quo_big ? S32_MAX : $signed(div_quo[DATA_W-1:0]);

        mul_src   = (ctrl.op == OP_MUL_Q) ? sel_q : sel_v;
        prod_next = mul_src * $signed({1'b0, item_dt_reg});

        inc  = prod_reg[PROD_W-1:STEP_FRAC];
        base = (ctrl.op == OP_ADD_V) ? sel_v : sel_p;
        sum  = WIDE_W'(base) + WIDE_W'(inc);

        bound_next = $signed(BOUND_W'({1'b0, sel_arena}) - BOUND_W'({radius_reg, 1'b0}));
        mirror     = (WIDE_W'(bound_reg) <<< 1) - WIDE_W'(sel_p);
        lo_hit     = (sel_p <= 0);
        hi_hit     = (WIDE_W'(sel_p) >= WIDE_W'(bound_reg));

        out_full = out_valid_reg && !out_ready;

        p_we  = 1'b0;
        v_we  = 1'b0;
        p_new = sel_p;
        v_new = sel_v;
        case (ctrl.op)
            OP_ADD_P:
            begin
                p_we  = 1'b1;
                p_new = sat32(sum);
            end
            OP_ADD_V:
            begin
                v_we  = 1'b1;
                v_new = sat32(sum);
            end
            OP_REFL_LO:
            begin
                p_we  = lo_hit;
                v_we  = lo_hit;
                p_new = sat32(-WIDE_W'(sel_p));
                v_new = neg_half(sel_v);
            end
            OP_REFL_HI:
            begin
                p_we  = hi_hit;
                v_we  = hi_hit;
                p_new = sat32(mirror);
                v_new = neg_half(sel_v);
            end
            default:
            begin
                p_we = 1'b0;
                v_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_x_reg   <= '0;
            accel_y_reg   <= '0;
            mass_reg      <= MASS_RST;
            radius_reg    <= RADIUS_RST;
            arena_len_reg <= LENGTH_RST;
            arena_hgt_reg <= HEIGHT_RST;
            dirty_reg     <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            qx_reg        <= '0;
            qy_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.op == OP_CLEAN)
                dirty_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ACCEL_X:
                    begin
                        accel_x_reg <= $signed(cfg_data);
                        dirty_reg   <= 1'b1;
                    end
                    CFG_ACCEL_Y:
                    begin
                        accel_y_reg <= $signed(cfg_data);
                        dirty_reg   <= 1'b1;
                    end
                    CFG_MASS:
                    begin
                        mass_reg  <= cfg_data;
                        dirty_reg <= 1'b1;
                    end
                    CFG_RADIUS:    radius_reg    <= cfg_data;
                    CFG_ARENA_LEN: arena_len_reg <= cfg_data[ARENA_W-1:0];
                    CFG_ARENA_HGT: arena_hgt_reg <= cfg_data[ARENA_W-1:0];
                    default:       ;
                endcase
            end

            if (ctrl.op == OP_DIV_STORE)
            begin
                if (ctrl.axis)
                    qy_reg <= q_val;
                else
                    qx_reg <= q_val;
            end

            if (ctrl.op == OP_LOAD)
            begin
                px_reg <= item_x_reg;
                py_reg <= item_y_reg;
                vx_reg <= item_vx_reg;
                vy_reg <= item_vy_reg;
            end
            else
            begin
                if (p_we && !ctrl.axis)
                    px_reg <= p_new;
                if (p_we && ctrl.axis)
                    py_reg <= p_new;
                if (v_we && !ctrl.axis)
                    vx_reg <= v_new;
                if (v_we && ctrl.axis)
                    vy_reg <= v_new;
            end

            if (ctrl.op == OP_OUT && !out_full)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_load_reg <= req_type;
            item_dt_reg   <= time_step;
            item_x_reg    <= load_x;
            item_y_reg    <= load_y;
            item_vx_reg   <= load_vx;
            item_vy_reg   <= load_vy;
        end
        if (ctrl.op == OP_MUL_V || ctrl.op == OP_MUL_Q)
            prod_reg <= prod_next;
        if (ctrl.op == OP_BOUND)
            bound_reg <= bound_next;
        if (ctrl.op == OP_OUT && !out_full)
        begin
            out_x_reg  <= px_reg;
            out_y_reg  <= py_reg;
            out_vx_reg <= vx_reg;
            out_vy_reg <= vy_reg;
        end
    end

    assign stat.is_load  = item_load_reg;
    assign stat.dirty    = dirty_reg;
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_full;

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_vx    = out_vx_reg;
    assign out_vy    = out_vy_reg;

endmodule

[rtl/bbe_seq.sv]
// Microcode sequencer: step counter, control-word fetch and conditional jumps.
module bbe_seq import bbe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  stat_t stat,
    output ctrl_t ctrl,
    output logic  ready
);

    logic            run_reg, run_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          word;
    logic            taken;

    always_comb
    begin
        word = ucode_rom(pc_reg);
        case (word.jc)
            JC_NONE:     taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_LOAD:     taken = stat.is_load;
            JC_CLEAN:    taken = !stat.dirty;
            JC_DIV_BUSY: taken = stat.div_busy;
            JC_OUT_FULL: taken = stat.out_full;
            default:     taken = 1'b0;
        endcase

        run_next = run_reg;
        pc_next  = pc_reg;
        if (!run_reg)
        begin
            if (accept)
            begin
                run_next = 1'b1;
                pc_next  = '0;
            end
        end
        else if (taken)
            pc_next = word.target;
        else if (word.last)
            run_next = 1'b0;
        else
            pc_next = pc_reg + 1'b1;

        ctrl.op   = run_reg ? word.op : OP_NOP;
        ctrl.axis = word.axis;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= '0;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
        end
    end

    assign ready = !run_reg;

endmodule

[rtl/bbe_chk.sv]
// Port-level checker for the ball stepper, bound to the top level.
module bbe_chk import bbe_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DATA_W-1:0] rsp_x,
    input logic [DATA_W-1:0] rsp_y,
    input logic [DATA_W-1:0] rsp_vx,
    input logic [DATA_W-1:0] rsp_vy
);

    // one word in flight: no second acceptance straight after the first
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a word is in flight");

    // a result only appears as the end of work on an accepted word
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result raised while idle");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped before it was taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_y) &&
                                    $stable(rsp_vx) && $stable(rsp_vy))
        else $error("result changed while stalled");

endmodule

bind bouncing_ball_euler_step bbe_chk u_bbe_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_x     (rsp.out_x),
    .rsp_y     (rsp.out_y),
    .rsp_vx    (rsp.out_vx),
    .rsp_vy    (rsp.out_vy)
);

[verif/ball_tb_pkg.sv]
// Request codes and the ball state record shared by the ball stepper testbench.
`timescale 1ns / 100ps
package ball_tb_pkg;
    import bbe_pkg::*;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
    } ball_t;

endpackage

[verif/ball_motion_checker.sv]
// Checker that predicts the ball state for every request word and compares each result word.
`timescale 1ns / 100ps
module ball_motion_checker
    import bbe_pkg::*;
    import ball_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    bbe_req_if                   req,
    bbe_rsp_if                   rsp,
    output int                   fail_count,
    output int                   pending_words
);

    ball_t                    ball;
    ball_t                    expected_balls[$];
    logic signed [DATA_W-1:0] push_x;
    logic signed [DATA_W-1:0] push_y;
    logic [DATA_W-1:0]        mass;
    logic [DATA_W-1:0]        radius;
    logic [ARENA_W-1:0]       arena_len;
    logic [ARENA_W-1:0]       arena_hgt;

    function automatic longint clamp32(longint v);
        if (v > longint'(S32_MAX))
            return longint'(S32_MAX);
        if (v < longint'(S32_MIN))
            return longint'(S32_MIN);
        return v;
    endfunction

    // acceleration = force / mass in Q.F, truncated toward zero
    function automatic longint push_per_mass(logic signed [DATA_W-1:0] push,
                                             logic [DATA_W-1:0] m);
        longint          a;
        longint unsigned mag;
        longint unsigned q;
        a = push;
        if (m == '0)
        begin
            if (a > 0)
                return longint'(S32_MAX);
            if (a < 0)
                return longint'(S32_MIN);
            return 0;
        end
        mag = (a < 0) ? -a : a;
        q = (mag << FRAC_BITS) / {32'd0, m};
        return (a < 0) ? clamp32(-longint'(q)) : clamp32(longint'(q));
    endfunction

    // low wall first, then the high wall on the updated values
    function automatic void bounce(inout longint p, inout longint v, input longint bound);
        if (p <= 0)
        begin
            p = clamp32(-p);
            v = (-v) >>> 1;
        end
        if (p >= bound)
        begin
            p = clamp32(2 * bound - p);
            v = (-v) >>> 1;
        end
    endfunction

    function automatic ball_t advance_ball(ball_t s, logic [DT_W-1:0] dt_bits);
        longint dt;
        longint px;
        longint py;
        longint vx;
        longint vy;
        longint qx;
        longint qy;
        longint span;
        longint bound_x;
        longint bound_y;
        ball_t  n;
        dt = dt_bits;
        px = $signed(s.x);
        py = $signed(s.y);
        vx = $signed(s.vx);
        vy = $signed(s.vy);
        qx = push_per_mass(push_x, mass);
        qy = push_per_mass(push_y, mass);
        px = clamp32(px + ((vx * dt) >>> STEP_FRAC));
        py = clamp32(py + ((vy * dt) >>> STEP_FRAC));
        vx = clamp32(vx + ((qx * dt) >>> STEP_FRAC));
        vy = clamp32(vy + ((qy * dt) >>> STEP_FRAC));
        span = radius;
        bound_x = arena_len;
        bound_y = arena_hgt;
        bound_x = bound_x - 2 * span;
        bound_y = bound_y - 2 * span;
        bounce(px, vx, bound_x);
        bounce(py, vy, bound_y);
        n.x  = px[DATA_W-1:0];
        n.y  = py[DATA_W-1:0];
        n.vx = vx[DATA_W-1:0];
        n.vy = vy[DATA_W-1:0];
        return n;
    endfunction

    function automatic int differs(string field, logic signed [DATA_W-1:0] want,
                                   logic signed [DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ball_t want;
        int    bad;
        if (!rst_n)
        begin
            ball = '0;
            expected_balls.delete();
            push_x = '0;
            push_y = '0;
            mass = MASS_RST;
            radius = RADIUS_RST;
            arena_len = LENGTH_RST;
            arena_hgt = HEIGHT_RST;
            pending_words <= 0;
            fail_count <= 0;
        end
        else
        begin
            bad = 0;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ACCEL_X:   push_x = cfg_data;
                    CFG_ACCEL_Y:   push_y = cfg_data;
                    CFG_MASS:      mass = cfg_data;
                    CFG_RADIUS:    radius = cfg_data;
                    CFG_ARENA_LEN: arena_len = cfg_data[ARENA_W-1:0];
                    CFG_ARENA_HGT: arena_hgt = cfg_data[ARENA_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_balls.size() == 0)
                begin
                    $error("result word with no request outstanding");
                    bad++;
                end
                else
                begin
                    want = expected_balls.pop_front();
                    bad += differs("out_x", want.x, rsp.out_x);
                    bad += differs("out_y", want.y, rsp.out_y);
                    bad += differs("out_vx", want.vx, rsp.out_vx);
                    bad += differs("out_vy", want.vy, rsp.out_vy);
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_LOAD)
                    ball = '{req.load_x, req.load_y, req.load_vx, req.load_vy};
                else
                    ball = advance_ball(ball, req.time_step);
                expected_balls.push_back(ball);
            end
            pending_words <= expected_balls.size();
            fail_count <= fail_count + bad;
        end
    end

endmodule

[verif/tb_bouncing_ball_euler_step.sv]
// Testbench top for the ball stepper: stimulus, register set-ups, output stalls and verdict.
`timescale 1ns / 100ps
module tb_bouncing_ball_euler_step;
    import bbe_pkg::*;
    import ball_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 103;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int DT_UNIT     = 1 << STEP_FRAC;
    localparam logic [DT_W-1:0] DT_MAX = '1;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_CHOPPY,
        DRAIN_SLOW
    } drain_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     rsp_take = 1'b0;
    int                       fail_count;
    int                       pending_words;
    int                       cycles = 0;
    int                       words_sent = 0;
    int                       burst_left = 0;
    int                       stall_left = 0;
    int                       mode_left = 0;
    drain_mode_t              drain_mode = DRAIN_FREE;
    logic [DATA_W-1:0]        mass;
    logic [DATA_W-1:0]        radius;
    logic [ARENA_W-1:0]       arena_len;
    logic [ARENA_W-1:0]       arena_hgt;

    bbe_req_if req ();
    bbe_rsp_if rsp ();

    assign rsp.ready = rsp_take;

    bouncing_ball_euler_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    ball_motion_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req           (req),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending_words (pending_words)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: free-running, short chops or long stalls, switched now and then
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 400);
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            rsp_take <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_take <= 1'b1;
            if (drain_mode == DRAIN_CHOPPY && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 3);
            else if (drain_mode == DRAIN_SLOW && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(4, 25);
        end
    end

    function automatic logic signed [DATA_W-1:0] jitter(int unsigned span);
        logic signed [DATA_W-1:0] m;
        m = $urandom_range(0, span);
        return ($urandom_range(0, 1) == 1) ? -m : m;
    endfunction

    task automatic send_word(logic kind, logic [DT_W-1:0] dt,
                             logic signed [DATA_W-1:0] x, logic signed [DATA_W-1:0] y,
                             logic signed [DATA_W-1:0] vx, logic signed [DATA_W-1:0] vy);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req.valid     <= 1'b1;
        req.req_type  <= kind;
        req.time_step <= dt;
        req.load_x    <= x;
        req.load_y    <= y;
        req.load_vx   <= vx;
        req.load_vy   <= vy;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        burst_left--;
        words_sent++;
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // registers only change once every result is back
    task automatic settle_and_configure(logic signed [DATA_W-1:0] ax,
                                        logic signed [DATA_W-1:0] ay,
                                        logic [DATA_W-1:0] m, logic [DATA_W-1:0] r,
                                        logic [DATA_W-1:0] len, logic [DATA_W-1:0] hgt);
        req.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        mass = m;
        radius = r;
        arena_len = len[ARENA_W-1:0];
        arena_hgt = hgt[ARENA_W-1:0];
        cfg_write(CFG_ACCEL_X, ax);
        cfg_write(CFG_ACCEL_Y, ay);
        cfg_write(CFG_MASS, m);
        cfg_write(CFG_RADIUS, r);
        cfg_write(CFG_ARENA_LEN, len);
        cfg_write(CFG_ARENA_HGT, hgt);
        cfg_we <= 1'b0;
    endtask

    // mostly a load inside the arena followed by a run of ticks; the rest is noise
    task automatic random_words(int count);
        int                       target;
        longint                   span;
        longint                   bound_x;
        longint                   bound_y;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic [DT_W-1:0]          dt;
        target = words_sent + count;
        while (words_sent < target)
        begin
            case ($urandom_range(0, 9))
                7, 8:
                    send_word(1'($urandom_range(0, 1)), DT_W'($urandom_range(0, 65535)),
                              $urandom(), $urandom(), $urandom(), $urandom());
                9:
                    send_word(REQ_TICK, DT_W'($urandom_range(0, 65535)),
                              $urandom(), $urandom(), $urandom(), $urandom());
                default:
                begin
                    span = radius;
                    bound_x = arena_len;
                    bound_y = arena_hgt;
                    bound_x = bound_x - 2 * span;
                    bound_y = bound_y - 2 * span;
                    px = (bound_x > 0) ? $urandom_range(0, 32'(bound_x))
                                       : $urandom_range(0, 100 * ONE);
                    py = (bound_y > 0) ? $urandom_range(0, 32'(bound_y))
                                       : $urandom_range(0, 100 * ONE);
                    send_word(REQ_LOAD, DT_W'($urandom()), px, py,
                              jitter(400 * ONE), jitter(400 * ONE));
                    repeat ($urandom_range(3, 15))
                    begin
                        dt = DT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(1, DT_UNIT));
                        send_word(REQ_TICK, dt, $urandom(), $urandom(), $urandom(), $urandom());
                    end
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_ACCEL_X;
        cfg_data      <= '0;
        req.valid     <= 1'b0;
        req.req_type  <= REQ_TICK;
        req.time_step <= '0;
        req.load_x    <= '0;
        req.load_y    <= '0;
        req.load_vx   <= '0;
        req.load_vy   <= '0;
        mass = MASS_RST;
        radius = RADIUS_RST;
        arena_len = LENGTH_RST;
        arena_hgt = HEIGHT_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset set-up: resting ball, plain flight, both high walls, saturation, rounding
        send_word(REQ_TICK, '0, '0, '0, '0, '0);
        send_word(REQ_LOAD, '0, 100 * ONE, 50 * ONE, 30 * ONE, -20 * ONE);
        send_word(REQ_TICK, DT_W'(DT_UNIT), '0, '0, '0, '0);
        send_word(REQ_TICK, DT_MAX, '0, '0, '0, '0);
        send_word(REQ_LOAD, DT_MAX, 619 * ONE, 459 * ONE, 100 * ONE, 100 * ONE);
        send_word(REQ_TICK, DT_W'(DT_UNIT), '0, '0, '0, '0);
        send_word(REQ_LOAD, '0, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
        send_word(REQ_TICK, DT_MAX, '1, '1, '1, '1);
        send_word(REQ_LOAD, '0, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
        send_word(REQ_TICK, DT_MAX, '0, '0, '0, '0);
        send_word(REQ_LOAD, '0, '0, '0, -1, 1);
        send_word(REQ_TICK, DT_W'(1), '0, '0, '0, '0);
        send_word(REQ_LOAD, '0, -5 * ONE, 3 * ONE, -7, 32'sh0000_7fff);
        send_word(REQ_TICK, DT_W'(DT_UNIT / 2), '0, '0, '0, '0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    // zero mass, widest arena, zero height
                    settle_and_configure(S32_MAX, S32_MIN, '0, '0, 32'h7fff_ffff, '0);
                    send_word(REQ_LOAD, '0, 10 * ONE, 10 * ONE, ONE, ONE);
                    send_word(REQ_TICK, DT_W'(DT_UNIT), '0, '0, '0, '0);
                    send_word(REQ_TICK, DT_MAX, '0, '0, '0, '0);
                end
                1:
                begin
                    // quotient overflow, wall bound far below zero
                    settle_and_configure(S32_MIN, S32_MAX, 32'd1, '1, '0, 32'h7fff_ffff);
                    send_word(REQ_LOAD, '0, 5 * ONE, -5 * ONE, -3 * ONE, 3 * ONE);
                    send_word(REQ_TICK, DT_W'(DT_UNIT), '0, '0, '0, '0);
                    send_word(REQ_TICK, DT_MAX, '0, '0, '0, '0);
                end
                2:
                begin
                    settle_and_configure('0, '0, '1, RADIUS_RST, LENGTH_RST, HEIGHT_RST);
                    send_word(REQ_LOAD, '0, 300 * ONE, 200 * ONE, -50 * ONE, 70 * ONE);
                    send_word(REQ_TICK, DT_W'(DT_UNIT), '0, '0, '0, '0);
                end
                default:
                begin
                    if (phase % 3 == 0)
                        settle_and_configure($urandom(), $urandom(), $urandom(), $urandom(),
                                             $urandom(), $urandom());
                    else
                        settle_and_configure(jitter(40 * ONE), jitter(40 * ONE),
                                             $urandom_range(ONE / 4, 8 * ONE),
                                             $urandom_range(0, 20 * ONE),
                                             $urandom_range(60 * ONE, 1000 * ONE),
                                             $urandom_range(60 * ONE, 1000 * ONE));
                end
            endcase
            random_words(PHASE_WORDS);
        end

        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_words == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/bbe_pkg.sv
rtl/bbe_if.sv
rtl/bbe_div.sv
rtl/bbe_dp.sv
rtl/bbe_seq.sv
rtl/bouncing_ball_euler_step.sv
rtl/bbe_chk.sv
verif/ball_tb_pkg.sv
verif/ball_motion_checker.sv
verif/tb_bouncing_ball_euler_step.sv
